// ===== sv/tpq_pkg.sv =====
// Package for the two-priority linked message queue.
// Holds the word types, request and status codes, controller types and
// the byte mask helper. It depends on nothing else.
`timescale 1ns / 1ps

package tpq_pkg;

	localparam int POOL_DEPTH_DEF        = 16;
	localparam int MAX_MESSAGE_BYTES_DEF = 8;
	localparam int DATA_W                = 64;
	localparam int BYTES_W               = 4;

	localparam logic [1:0] REQ_SEND_N = 2'd0;
	localparam logic [1:0] REQ_SEND_U = 2'd1;
	localparam logic [1:0] REQ_RECV   = 2'd2;
	localparam logic [1:0] REQ_NOP    = 2'd3;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	localparam logic [BYTES_W-1:0] ELEM_BYTES_RST = 4'd8;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [DATA_W-1:0]  message_data;
		logic [BYTES_W-1:0] byte_count;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] received_data;
		logic              was_urgent;
	} rsp_t;

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_COMMIT
	} state_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_FULL,
		OP_EMPTY,
		OP_SEND_N,
		OP_SEND_U,
		OP_RECV_N,
		OP_RECV_U
	} op_t;

	typedef struct packed {
		logic init_wr;
		logic issue;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic init_last;
	} sts_t;

	// Mask that keeps the low len bytes of a word.
	function automatic logic [DATA_W-1:0] byte_mask(input logic [BYTES_W-1:0] len);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < DATA_W / 8; b++) begin
			m[b*8 +: 8] = (BYTES_W'(b) < len) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

// ===== sv/tpq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the node link and node payload stores; no dependencies.
`timescale 1ns / 1ps

module tpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/tpq_ctrl.sv =====
// Controller of the message queue: link initialization, issue and commit.
// Uses tpq_pkg for the state, command and status types.
`timescale 1ns / 1ps

module tpq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  tpq_pkg::sts_t sts,
	output tpq_pkg::cmd_t cmd
);
	import tpq_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// The result register can take a new word when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (sts.init_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	always_comb begin
		cmd.init_wr = 1'b0;
		cmd.issue   = 1'b0;
		cmd.commit  = 1'b0;
		in_stall    = 1'b1;
		unique case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
			end
			S_IDLE: begin
				in_stall  = 1'b0;
				cmd.issue = in_valid;
			end
			S_COMMIT: begin
				cmd.commit = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/tpq_dp.sv =====
// Datapath of the message queue: list pointers and counts, the link and
// payload memories, the element size register and the result register.
// Uses tpq_pkg and tpq_ram.
`timescale 1ns / 1ps

module tpq_dp #(
	parameter int POOL_DEPTH        = tpq_pkg::POOL_DEPTH_DEF,
	parameter int MAX_MESSAGE_BYTES = tpq_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [tpq_pkg::BYTES_W-1:0]   cfg_wr_data,
	input  tpq_pkg::req_t                 in_word,
	output tpq_pkg::rsp_t                 out_word,
	input  tpq_pkg::cmd_t                 cmd,
	output tpq_pkg::sts_t                 sts
);
	import tpq_pkg::*;

	localparam int IW = $clog2(POOL_DEPTH);
	localparam int CW = $clog2(POOL_DEPTH + 1);
	localparam int PW = 8 * MAX_MESSAGE_BYTES;
	localparam logic [IW-1:0]      LAST_NODE = IW'(POOL_DEPTH - 1);
	localparam logic [BYTES_W-1:0] MAX_BYTES = BYTES_W'(MAX_MESSAGE_BYTES);

	logic [IW-1:0] free_head_q, free_tail_q, nrm_head_q, nrm_tail_q, urg_head_q, urg_tail_q;
	logic [CW-1:0] free_cnt_q, nrm_cnt_q, urg_cnt_q;
	logic [BYTES_W-1:0] elem_bytes_q;
	logic [IW-1:0] init_q;

	op_t                op_q, op_d;
	logic [IW-1:0]      node_q, node_d;
	logic [BYTES_W-1:0] len_q, len_d, eff_bytes;
	rsp_t               out_q;

	logic          lk_we, rd_en, pl_we;
	logic [IW-1:0] lk_waddr, lk_wdata, lk_rdata;
	logic [PW-1:0] pl_wdata, pl_rdata;
	logic [DATA_W-1:0] in_mask, out_mask, rd_ext;

	assign sts.init_last = (init_q == LAST_NODE);

	// Copy length is the byte count cut to the effective element size.
	assign eff_bytes = (elem_bytes_q > MAX_BYTES) ? MAX_BYTES : elem_bytes_q;
	assign len_d     = (in_word.byte_count < eff_bytes) ? in_word.byte_count : eff_bytes;
	assign in_mask   = byte_mask(len_d);
	assign pl_wdata  = in_word.message_data[PW-1:0] & in_mask[PW-1:0];

	always_comb begin
		op_d     = OP_NOP;
		node_d   = free_head_q;
		rd_en    = 1'b0;
		pl_we    = 1'b0;
		lk_we    = cmd.init_wr;
		lk_waddr = init_q;
		lk_wdata = (init_q == LAST_NODE) ? '0 : init_q + IW'(1);
		if (cmd.issue) begin
			case (in_word.req_type) inside
				REQ_SEND_N, REQ_SEND_U: begin
					if (free_cnt_q == '0) begin
						op_d = OP_FULL;
					end else begin
						node_d = free_head_q;
						rd_en  = 1'b1;
						pl_we  = 1'b1;
						if (in_word.req_type == REQ_SEND_U) begin
							op_d = OP_SEND_U;
							if (urg_cnt_q != '0) begin
								lk_we    = 1'b1;
								lk_waddr = urg_tail_q;
								lk_wdata = free_head_q;
							end
						end else begin
							op_d = OP_SEND_N;
							if (nrm_cnt_q != '0) begin
								lk_we    = 1'b1;
								lk_waddr = nrm_tail_q;
								lk_wdata = free_head_q;
							end
						end
					end
				end
				REQ_RECV: begin
					if (urg_cnt_q != '0) begin
						op_d   = OP_RECV_U;
						node_d = urg_head_q;
					end else if (nrm_cnt_q != '0) begin
						op_d   = OP_RECV_N;
						node_d = nrm_head_q;
					end else begin
						op_d = OP_EMPTY;
					end
					if (op_d != OP_EMPTY) begin
						rd_en = 1'b1;
						if (free_cnt_q != '0) begin
							lk_we    = 1'b1;
							lk_waddr = free_tail_q;
							lk_wdata = node_d;
						end
					end
				end
				default: op_d = OP_NOP;
			endcase
		end
	end

	// Link of the popped node is read in the issue cycle and used at commit.
	tpq_ram #(.WIDTH(IW), .DEPTH(POOL_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.re    (rd_en),
		.raddr (node_d),
		.rdata (lk_rdata)
	);

	tpq_ram #(.WIDTH(PW), .DEPTH(POOL_DEPTH)) u_payload_ram (
		.clk   (clk),
		.we    (pl_we),
		.waddr (node_d),
		.wdata (pl_wdata),
		.re    (rd_en),
		.raddr (node_d),
		.rdata (pl_rdata)
	);

	assign out_mask = byte_mask(len_q);
	assign rd_ext   = DATA_W'(pl_rdata) & out_mask;

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			op_q   <= op_d;
			node_q <= node_d;
			len_q  <= len_d;
		end
		if (cmd.commit) begin
			out_q.status        <= STS_OK;
			out_q.received_data <= '0;
			out_q.was_urgent    <= 1'b0;
			case (op_q)
				OP_FULL:  out_q.status <= STS_FULL;
				OP_EMPTY: out_q.status <= STS_EMPTY;
				OP_RECV_N: out_q.received_data <= rd_ext;
				OP_RECV_U: begin
					out_q.received_data <= rd_ext;
					out_q.was_urgent    <= 1'b1;
				end
				default: out_q.status <= STS_OK;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q       <= '0;
			elem_bytes_q <= ELEM_BYTES_RST;
			free_head_q  <= '0;
			free_tail_q  <= LAST_NODE;
			free_cnt_q   <= CW'(POOL_DEPTH);
			nrm_head_q   <= '0;
			nrm_tail_q   <= '0;
			nrm_cnt_q    <= '0;
			urg_head_q   <= '0;
			urg_tail_q   <= '0;
			urg_cnt_q    <= '0;
		end else begin
			if (cmd.init_wr) begin
				init_q <= init_q + IW'(1);
			end
			if (cfg_wr_en) begin
				elem_bytes_q <= cfg_wr_data;
			end
			if (cmd.commit) begin
				case (op_q)
					OP_SEND_N, OP_SEND_U: begin
						free_cnt_q <= free_cnt_q - CW'(1);
						if (free_cnt_q == CW'(1)) begin
							free_head_q <= '0;
							free_tail_q <= '0;
						end else begin
							free_head_q <= lk_rdata;
						end
						if (op_q == OP_SEND_U) begin
							if (urg_cnt_q == '0) urg_head_q <= node_q;
							urg_tail_q <= node_q;
							urg_cnt_q  <= urg_cnt_q + CW'(1);
						end else begin
							if (nrm_cnt_q == '0) nrm_head_q <= node_q;
							nrm_tail_q <= node_q;
							nrm_cnt_q  <= nrm_cnt_q + CW'(1);
						end
					end
					OP_RECV_N, OP_RECV_U: begin
						if (op_q == OP_RECV_U) begin
							urg_cnt_q <= urg_cnt_q - CW'(1);
							if (urg_cnt_q == CW'(1)) begin
								urg_head_q <= '0;
								urg_tail_q <= '0;
							end else begin
								urg_head_q <= lk_rdata;
							end
						end else begin
							nrm_cnt_q <= nrm_cnt_q - CW'(1);
							if (nrm_cnt_q == CW'(1)) begin
								nrm_head_q <= '0;
								nrm_tail_q <= '0;
							end else begin
								nrm_head_q <= lk_rdata;
							end
						end
						if (free_cnt_q == '0) free_head_q <= node_q;
						free_tail_q <= node_q;
						free_cnt_q  <= free_cnt_q + CW'(1);
					end
					default: free_cnt_q <= free_cnt_q;
				endcase
			end
		end
	end

	assign out_word = out_q;

endmodule

// ===== sv/two_priority_linked_message_queue.sv =====
// Two-priority message queue over a shared pool of POOL_DEPTH nodes kept on
// free, normal and urgent linked lists. A request word is taken only while
// in_stall is low and produces exactly one response word: the link and
// payload memories are read at the accepting edge, and the list update
// commits into the result register once that register is free. A new
// request is not taken until the current one has committed, since the link
// memory read is registered; a stalled response holds the commit. After
// reset the block initializes the free chain in the link memory, holding
// in_stall high meanwhile; writes of element_bytes are taken at any time.
// Depends on tpq_pkg, tpq_ctrl, tpq_dp.
`timescale 1ns / 1ps

module two_priority_linked_message_queue #(
	parameter int POOL_DEPTH        = tpq_pkg::POOL_DEPTH_DEF,
	parameter int MAX_MESSAGE_BYTES = tpq_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [tpq_pkg::BYTES_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  tpq_pkg::req_t               in_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output tpq_pkg::rsp_t               out_word
);
	import tpq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tpq_dp #(
		.POOL_DEPTH        (POOL_DEPTH),
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_word     (in_word),
		.out_word    (out_word),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

// ===== sv/tpq_checker.sv =====
// Port-level checker for the message queue, bound to the top level.
// Uses tpq_pkg for the word types and status codes.
`timescale 1ns / 1ps

module tpq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input tpq_pkg::rsp_t out_word
);
	import tpq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled response word changed or dropped");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.status == STS_OK || out_word.status == STS_EMPTY ||
			out_word.status == STS_FULL))
		else $error("response carries an undefined status");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status != STS_OK |->
			out_word.received_data == '0 && !out_word.was_urgent)
		else $error("failed request returned data");

	// Once a request is taken, in_stall must be high, so no second request enters while one is in flight.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another is in flight");

endmodule

bind two_priority_linked_message_queue tpq_checker u_tpq_checker (.*);
